### sv/wlcp_pkg.sv
// wlcp_pkg: shared constants, types and helpers of the wireless link command parser
`timescale 1ns / 1ps
`default_nettype none

package wlcp_pkg;

  localparam int unsigned LINE_DEPTH = 64;
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LINE_DEPTH + 1);

  localparam int unsigned KW_CONNECT_LEN = 7;
  localparam int unsigned KW_CLOSED_LEN  = 6;

  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [15:0] THROTTLE_EXIT = 16'd100;
  localparam logic [15:0] THROTTLE_MAX  = 16'd2850;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_CONNECTED = 4'd1,
    EV_CLOSED    = 4'd2,
    EV_ANGLES    = 4'd3,
    EV_KP        = 4'd4,
    EV_KI        = 4'd5,
    EV_KD        = 4'd6,
    EV_THROTTLE  = 4'd7,
    EV_OVERFLOW  = 4'd8,
    EV_UNKNOWN   = 4'd9
  } event_e;

  typedef enum logic [4:0] {
    ST_WAIT   = 5'b00001,
    ST_OPEN   = 5'b00010,
    ST_RECV   = 5'b00100,
    ST_CLOSED = 5'b01000,
    ST_WALK   = 5'b10000
  } state_e;

  typedef struct packed {
    logic   kw_step;
    logic   kw_closed;
    logic   collect_set;
    logic   store;
    logic   frame_clear;
    logic   walk_start;
    logic   walk_run;
    logic   out_load;
    logic   out_frame;
    event_e out_ev;
    logic   out_link;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_plus;
    logic is_zero;
    logic is_colon;
    logic collecting;
    logic full;
    logic kw_hit;
    logic ok_hit;
    logic walk_done;
  } dp_status_t;

  function automatic logic [7:0] kw_char(input logic closed, input logic [2:0] idx);
    logic [7:0] ch;
    ch = CH_C;
    if (closed) begin
      unique case (idx)
        3'd0:    ch = CH_C;
        3'd1:    ch = CH_L;
        3'd2:    ch = CH_O;
        3'd3:    ch = CH_S;
        3'd4:    ch = CH_E;
        3'd5:    ch = CH_D;
        default: ch = CH_C;
      endcase
    end else begin
      unique case (idx)
        3'd0:    ch = CH_C;
        3'd1:    ch = CH_O;
        3'd2:    ch = CH_N;
        3'd3:    ch = CH_N;
        3'd4:    ch = CH_E;
        3'd5:    ch = CH_C;
        3'd6:    ch = CH_T;
        default: ch = CH_C;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

### sv/wlcp_ram.sv
// wlcp_ram: generic single write port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module wlcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/wlcp_ctrl.sv
// wlcp_ctrl: link mode state machine and handshake control
`timescale 1ns / 1ps
`default_nettype none

module wlcp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  input  wire wlcp_pkg::dp_status_t status_i,
  output wlcp_pkg::ctrl_cmd_t       cmd_o
);
  import wlcp_pkg::*;

  state_e     state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  ctrl_cmd_t  cmd;

  assign in_ready_o = (state_q != ST_WALK) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd             = '0;
    cmd.out_ev      = EV_NONE;
    unique case (state_q)
      ST_WAIT: begin
        cmd.kw_step  = accept;
        cmd.out_load = accept;
        if (accept && status_i.kw_hit) begin
          state_d    = ST_OPEN;
          cmd.out_ev = EV_CONNECTED;
        end
      end
      ST_OPEN: begin
        cmd.out_load = accept;
        if (accept && status_i.is_plus) begin
          state_d = ST_RECV;
        end else if (accept && status_i.is_zero) begin
          state_d = ST_CLOSED;
        end
      end
      ST_RECV: begin
        if (accept) begin
          cmd.out_load = 1'b1;
          if (status_i.is_colon) begin
            cmd.collect_set = 1'b1;
          end else if (status_i.collecting) begin
            if (status_i.full) begin
              cmd.out_ev      = EV_OVERFLOW;
              cmd.frame_clear = 1'b1;
              state_d         = ST_OPEN;
            end else begin
              cmd.store = 1'b1;
              if (status_i.ok_hit) begin
                cmd.out_load   = 1'b0;
                cmd.walk_start = 1'b1;
                state_d        = ST_WALK;
              end
            end
          end
        end
      end
      ST_CLOSED: begin
        cmd.kw_step   = accept;
        cmd.kw_closed = 1'b1;
        cmd.out_load  = accept;
        if (accept && status_i.kw_hit) begin
          state_d    = ST_WAIT;
          cmd.out_ev = EV_CLOSED;
        end
      end
      ST_WALK: begin
        cmd.walk_run = 1'b1;
        if (status_i.walk_done) begin
          cmd.out_load    = 1'b1;
          cmd.out_frame   = 1'b1;
          cmd.frame_clear = 1'b1;
          state_d         = ST_OPEN;
        end
      end
      default: begin
        state_d = ST_WAIT;
      end
    endcase
    cmd.out_link = (state_d != ST_WAIT);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef SYNTHESIS
  a_walk_entry_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk_start |=> (state_q == ST_WALK) && !out_valid_q)
    else $error("walk entered with a pending result");

  a_walk_exit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) && (state_d == ST_OPEN) |=> out_valid_q)
    else $error("frame result not presented after walk");
`endif

endmodule

`default_nettype wire

### sv/wlcp_dpath.sv
// wlcp_dpath: keyword match, line store, payload walk and result register
`timescale 1ns / 1ps
`default_nettype none

module wlcp_dpath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           rx_byte_i,
  input  wire wlcp_pkg::ctrl_cmd_t  cmd_i,
  output wlcp_pkg::dp_status_t      status_o,
  output logic [3:0]                event_res_o,
  output logic                      link_up_o,
  output logic signed [15:0]        first_value_o,
  output logic signed [15:0]        second_value_o,
  output logic                      exit_request_o
);
  import wlcp_pkg::*;

  logic             collecting_q, collecting_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             mism_q, mism_d;
  logic [7:0]       prev_q, prev_d;
  logic [7:0]       cmdb_q, cmdb_d;
  logic [CNT_W-1:0] ra_q, ra_d;
  logic             pend_q, pend_d;
  logic [15:0]      acc_q, acc_d;
  logic [15:0]      v1_q, v1_d;
  logic [15:0]      v2_q, v2_d;
  logic [1:0]       num_q, num_d;

  event_e           ev_q, ev_d;
  logic             link_q, link_d;
  logic [15:0]      o1_q, o1_d;
  logic [15:0]      o2_q, o2_d;
  logic             ex_q, ex_d;

  logic             coll_eff;
  logic [CNT_W-1:0] fill_inc;
  logic [CNT_W-1:0] kw_len;
  logic             kw_last;
  logic             mism_now;
  logic [CNT_W:0]   ra_ext;
  logic             issue;
  logic [7:0]       rdata;
  logic [15:0]      digit;
  logic [15:0]      acc_next;
  logic             rd_star;
  event_e           frame_ev;
  logic [15:0]      frame_o1;
  logic [15:0]      frame_o2;
  logic             frame_ex;

  wlcp_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (ra_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // keyword tracking
  assign coll_eff = collecting_q || (rx_byte_i == CH_C);
  assign fill_inc = fill_q + CNT_W'(1);
  assign kw_len   = cmd_i.kw_closed ? CNT_W'(KW_CLOSED_LEN) : CNT_W'(KW_CONNECT_LEN);
  assign kw_last  = (fill_inc >= kw_len);
  assign mism_now = mism_q || (rx_byte_i != kw_char(cmd_i.kw_closed, fill_q[2:0]));

  // payload walk
  assign ra_ext   = {1'b0, ra_q} + (CNT_W+1)'(2);
  assign issue    = cmd_i.walk_run && (ra_ext < {1'b0, fill_q});
  assign digit    = {8'h00, rdata} - {8'h00, CH_ZERO};
  assign acc_next = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + digit;
  assign rd_star  = (rdata == CH_STAR);

  always_comb begin
    status_o.is_plus    = (rx_byte_i == CH_PLUS);
    status_o.is_zero    = (rx_byte_i == CH_ZERO);
    status_o.is_colon   = (rx_byte_i == CH_COLON);
    status_o.collecting = collecting_q;
    status_o.full       = (fill_q >= CNT_W'(LINE_DEPTH));
    status_o.kw_hit     = coll_eff && kw_last && !mism_now;
    status_o.ok_hit     = (fill_q != '0) && (prev_q == CH_O) && (rx_byte_i == CH_K);
    status_o.walk_done  = cmd_i.walk_run && !issue && !pend_q;
  end

  always_comb begin
    collecting_d = collecting_q;
    fill_d       = fill_q;
    mism_d       = mism_q;
    prev_d       = prev_q;
    cmdb_d       = cmdb_q;
    ra_d         = ra_q;
    pend_d       = 1'b0;
    acc_d        = acc_q;
    v1_d         = v1_q;
    v2_d         = v2_q;
    num_d        = num_q;

    if (cmd_i.kw_step && coll_eff) begin
      if (kw_last) begin
        collecting_d = 1'b0;
        fill_d       = '0;
        mism_d       = 1'b0;
      end else begin
        collecting_d = 1'b1;
        fill_d       = fill_inc;
        mism_d       = mism_now;
      end
    end
    if (cmd_i.collect_set) begin
      collecting_d = 1'b1;
    end
    if (cmd_i.store) begin
      fill_d = fill_inc;
      prev_d = rx_byte_i;
      if (fill_q == '0) begin
        cmdb_d = rx_byte_i;
      end
    end
    if (cmd_i.walk_start) begin
      ra_d  = CNT_W'(1);
      acc_d = '0;
      v1_d  = '0;
      v2_d  = '0;
      num_d = '0;
    end
    if (cmd_i.walk_run) begin
      pend_d = issue;
      if (issue) begin
        ra_d = ra_q + CNT_W'(1);
      end
      if (pend_q) begin
        if (cmdb_q == CH_S) begin
          if (rd_star) begin
            if (num_q == 2'd0) begin
              v1_d = acc_q;
            end
            if (num_q == 2'd1) begin
              v2_d = acc_q;
            end
            if (num_q != 2'd2) begin
              num_d = num_q + 2'd1;
            end
            acc_d = '0;
          end else begin
            acc_d = acc_next;
          end
        end else begin
          if (rd_star) begin
            v1_d = v1_q + acc_q;
          end
          acc_d = acc_next;
        end
      end
    end
    if (cmd_i.frame_clear) begin
      collecting_d = 1'b0;
      fill_d       = '0;
      mism_d       = 1'b0;
    end
  end

  // command decode at frame end
  always_comb begin
    frame_ev = EV_UNKNOWN;
    frame_o1 = '0;
    frame_o2 = '0;
    frame_ex = 1'b0;
    unique case (cmdb_q)
      CH_S: begin
        frame_ev = EV_ANGLES;
        frame_o1 = v1_q;
        frame_o2 = v2_q;
      end
      CH_P: begin
        frame_ev = EV_KP;
        frame_o1 = v1_q;
      end
      CH_I: begin
        frame_ev = EV_KI;
        frame_o1 = v1_q;
      end
      CH_D: begin
        frame_ev = EV_KD;
        frame_o1 = v1_q;
      end
      CH_T: begin
        frame_ev = EV_THROTTLE;
        if (v1_q == THROTTLE_EXIT) begin
          frame_o1 = THROTTLE_MAX;
          frame_ex = 1'b1;
        end else begin
          frame_o1 = v1_q;
        end
      end
      default: begin
        frame_ev = EV_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    ev_d   = ev_q;
    link_d = link_q;
    o1_d   = o1_q;
    o2_d   = o2_q;
    ex_d   = ex_q;
    if (cmd_i.out_load) begin
      link_d = cmd_i.out_link;
      if (cmd_i.out_frame) begin
        ev_d = frame_ev;
        o1_d = frame_o1;
        o2_d = frame_o2;
        ex_d = frame_ex;
      end else begin
        ev_d = cmd_i.out_ev;
        o1_d = '0;
        o2_d = '0;
        ex_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      fill_q       <= '0;
      mism_q       <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      collecting_q <= collecting_d;
      fill_q       <= fill_d;
      mism_q       <= mism_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    cmdb_q <= cmdb_d;
    ra_q   <= ra_d;
    acc_q  <= acc_d;
    v1_q   <= v1_d;
    v2_q   <= v2_d;
    num_q  <= num_d;
    ev_q   <= ev_d;
    link_q <= link_d;
    o1_q   <= o1_d;
    o2_q   <= o2_d;
    ex_q   <= ex_d;
  end

  assign event_res_o    = ev_q;
  assign link_up_o      = link_q;
  assign first_value_o  = $signed(o1_q);
  assign second_value_o = $signed(o2_q);
  assign exit_request_o = ex_q;

`ifndef SYNTHESIS
  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> (fill_q < CNT_W'(LINE_DEPTH)))
    else $error("line store written past its depth");

  a_keyword_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.kw_step |-> (fill_q < CNT_W'(KW_CONNECT_LEN)) && !cmd_i.store)
    else $error("keyword fill count out of range");
`endif

endmodule

`default_nettype wire

### sv/wifi_link_command_parser.sv
// wifi_link_command_parser: top level of the wireless link command parser
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    rx_byte_i
//   out      output     out_valid_o / out_ready_i  event_res_o, link_up_o, first_value_o,
//                                                  second_value_o, exit_request_o
//
// each byte but the one ending "OK" gives one result, registered the cycle after it is taken
// the byte that completes "OK" starts a walk over the stored payload, one RAM read a cycle
// input is held off during the walk and the frame result follows it
// a new byte is taken while the result register is empty or being taken
// rst_ni clears mode and counts asynchronously; no clearing pass on the line RAM
`timescale 1ns / 1ps
`default_nettype none

module wifi_link_command_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [3:0]              event_res_o,
  output logic                    link_up_o,
  output logic signed [15:0]      first_value_o,
  output logic signed [15:0]      second_value_o,
  output logic                    exit_request_o
);
  import wlcp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  wlcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wlcp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .event_res_o    (event_res_o),
    .link_up_o      (link_up_o),
    .first_value_o  (first_value_o),
    .second_value_o (second_value_o),
    .exit_request_o (exit_request_o)
  );

endmodule

`default_nettype wire

### dv/link_result_checker.sv
`timescale 1ns / 1ps
// link_result_checker: predicts and checks every result transfer of the link command parser
module link_result_checker
  import wlcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [3:0]         event_res_i,
  input  logic               link_up_i,
  input  logic signed [15:0] first_value_i,
  input  logic signed [15:0] second_value_i,
  input  logic               exit_request_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_RECV   = 2'd2,
    MODE_CLOSED = 2'd3
  } link_mode_e;

  typedef struct packed {
    logic [7:0]  src;
    event_e      ev;
    logic        link;
    logic [15:0] v1;
    logic [15:0] v2;
    logic        ex;
  } link_result_t;

  localparam logic [55:0] KW_CONNECT = "CONNECT";
  localparam logic [55:0] KW_CLOSED  = {8'h00, "CLOSED"};

  link_mode_e   mode_q;
  logic         gather_q;
  int unsigned  fill_q;
  logic [7:0]   line_q [LINE_DEPTH];
  logic         conn_q;
  link_result_t link_results_q [$];
  link_result_t want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s at %0t", msg, $time);
    fail_count_o++;
  endtask

  // decimal of line_q[lo .. hi-1], last byte weighted one, wrapping in 16 bits
  function automatic logic [15:0] decimal_at(input int unsigned lo, input int unsigned hi);
    logic [15:0] sum;
    logic [15:0] weight;
    int unsigned j;
    sum    = '0;
    weight = 16'd1;
    for (j = hi; j > lo; j--) begin
      sum    = sum + ({8'h00, line_q[j - 1]} - 16'd48) * weight;
      weight = weight * 16'd10;
    end
    return sum;
  endfunction

  // every star before the trailing OK adds the run from after the letter up to it
  function automatic logic [15:0] gain_value();
    logic [15:0] v;
    int unsigned i;
    v = '0;
    for (i = 1; i + 2 < fill_q; i++) begin
      if (line_q[i] == CH_STAR) v = v + decimal_at(1, i);
    end
    return v;
  endfunction

  function automatic logic keyword_take(input logic [7:0] b, input logic [55:0] kw,
                                        input int unsigned len);
    logic hit;
    int unsigned k;
    hit = 1'b1;
    if (b == CH_C) gather_q = 1'b1;
    if (!gather_q) return 1'b0;
    if (fill_q < LINE_DEPTH) line_q[fill_q] = b;
    fill_q++;
    if (fill_q < len) return 1'b0;
    gather_q = 1'b0;
    fill_q   = 0;
    for (k = 0; k < len; k++) begin
      if (line_q[k] != kw[8 * (len - 1 - k) +: 8]) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic void frame_done();
    mode_q   = MODE_OPEN;
    gather_q = 1'b0;
    fill_q   = 0;
  endfunction

  function automatic link_result_t predict_link_result(input logic [7:0] b);
    link_result_t r;
    int unsigned i;
    int unsigned start;
    int unsigned num;
    r     = '0;
    r.src = b;
    r.ev  = EV_NONE;
    case (mode_q)
      MODE_WAIT: begin
        if (keyword_take(b, KW_CONNECT, KW_CONNECT_LEN)) begin
          conn_q = 1'b1;
          mode_q = MODE_OPEN;
          r.ev   = EV_CONNECTED;
        end
      end
      MODE_OPEN: begin
        if (b == CH_PLUS) mode_q = MODE_RECV;
        else if (b == CH_ZERO) mode_q = MODE_CLOSED;
      end
      MODE_RECV: begin
        if (b == CH_COLON) begin
          gather_q = 1'b1;
        end else if (gather_q) begin
          if (fill_q >= LINE_DEPTH) begin
            r.ev = EV_OVERFLOW;
            frame_done();
          end else begin
            line_q[fill_q] = b;
            fill_q++;
            if (fill_q >= 2 && line_q[fill_q - 2] == CH_O && line_q[fill_q - 1] == CH_K) begin
              case (line_q[0])
                CH_S: begin
                  start = 1;
                  num   = 0;
                  for (i = 0; i + 2 < fill_q; i++) begin
                    if (line_q[i] == CH_STAR) begin
                      if (num == 0) r.v1 = decimal_at(start, i);
                      else if (num == 1) r.v2 = decimal_at(start, i);
                      num++;
                      start = i + 1;
                    end
                  end
                  r.ev = EV_ANGLES;
                end
                CH_P: begin
                  r.v1 = gain_value();
                  r.ev = EV_KP;
                end
                CH_I: begin
                  r.v1 = gain_value();
                  r.ev = EV_KI;
                end
                CH_D: begin
                  r.v1 = gain_value();
                  r.ev = EV_KD;
                end
                CH_T: begin
                  r.v1 = gain_value();
                  if (r.v1 == THROTTLE_EXIT) begin
                    r.v1 = THROTTLE_MAX;
                    r.ex = 1'b1;
                  end
                  r.ev = EV_THROTTLE;
                end
                default: r.ev = EV_UNKNOWN;
              endcase
              frame_done();
            end
          end
        end
      end
      default: begin
        if (keyword_take(b, KW_CLOSED, KW_CLOSED_LEN)) begin
          conn_q = 1'b0;
          mode_q = MODE_WAIT;
          r.ev   = EV_CLOSED;
        end
      end
    endcase
    r.link = conn_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   = MODE_WAIT;
      gather_q = 1'b0;
      fill_q   = 0;
      conn_q   = 1'b0;
      link_results_q.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) link_results_q.push_back(predict_link_result(rx_byte_i));
      if (out_valid_i && out_ready_i) begin
        if (link_results_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing pending, event %0d",
                                    event_res_i));
        end else begin
          want = link_results_q.pop_front();
          if (event_res_i !== want.ev)
            report_mismatch($sformatf("byte %h: event %0d, expected %0d",
                                      want.src, event_res_i, want.ev));
          if (link_up_i !== want.link)
            report_mismatch($sformatf("byte %h: link_up %b, expected %b",
                                      want.src, link_up_i, want.link));
          if (first_value_i !== want.v1)
            report_mismatch($sformatf("byte %h: first_value %h, expected %h",
                                      want.src, first_value_i, want.v1));
          if (second_value_i !== want.v2)
            report_mismatch($sformatf("byte %h: second_value %h, expected %h",
                                      want.src, second_value_i, want.v2));
          if (exit_request_i !== want.ex)
            report_mismatch($sformatf("byte %h: exit_request %b, expected %b",
                                      want.src, exit_request_i, want.ex));
        end
      end
      pending_o = link_results_q.size();
    end
  end

endmodule

### dv/wifi_link_command_parser_tb.sv
`timescale 1ns / 1ps
// wifi_link_command_parser_tb: byte stimulus of link sessions and frames, with the verdict
module wifi_link_command_parser_tb;
  import wlcp_pkg::*;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [7:0]        rx_byte_i   = 8'h00;
  logic              out_ready_i = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [3:0]        event_res_o;
  logic              link_up_o;
  logic signed [15:0] first_value_o;
  logic signed [15:0] second_value_o;
  logic              exit_request_o;

  logic       calm = 1'b0;
  int         fails;
  int         pending;
  int         sent_bytes = 0;
  int         sessions   = 0;
  int         frames     = 0;
  int         overruns   = 0;
  logic [7:0] burst_q [$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  wifi_link_command_parser u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .link_up_o      (link_up_o),
    .first_value_o  (first_value_o),
    .second_value_o (second_value_o),
    .exit_request_o (exit_request_o)
  );

  link_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_i    (event_res_o),
    .link_up_i      (link_up_o),
    .first_value_i  (first_value_o),
    .second_value_i (second_value_o),
    .exit_request_i (exit_request_o),
    .fail_count_o   (fails),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 27);
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gaps;
    gaps = 0;
    if (!calm) begin
      while ($urandom_range(99) < 27) gaps++;
    end
    if (gaps != 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sent_bytes++;
    calm <= (sent_bytes >= 150) && (sent_bytes < 280);
  endtask

  task automatic flush_burst();
    while (burst_q.size() != 0) send_byte(burst_q.pop_front());
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) burst_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (v == a || v == b);
    return v;
  endfunction

  // mostly decimal digits, now and then a stray byte; long runs wrap
  task automatic push_number();
    int unsigned n;
    int unsigned i;
    n = ($urandom_range(9) == 0) ? $urandom_range(8, 6) : $urandom_range(5, 1);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(11) == 0) burst_q.push_back(byte_except(CH_COLON, CH_K));
      else burst_q.push_back(8'(CH_ZERO + $urandom_range(9)));
    end
  endtask

  task automatic push_noise(input int unsigned n, input logic [7:0] a, input logic [7:0] b);
    int unsigned i;
    for (i = 0; i < n; i++) burst_q.push_back(byte_except(a, b));
  endtask

  // sometimes a keyword with one wrong byte ahead of the real one
  task automatic push_keyword(input string kw);
    int unsigned idx;
    int i;
    if ($urandom_range(4) == 0) begin
      idx = $urandom_range(kw.len() - 1, 1);
      for (i = 0; i < kw.len(); i++) begin
        if (i == idx) burst_q.push_back(byte_except(CH_C, kw[i]));
        else burst_q.push_back(kw[i]);
      end
    end
    push_text(kw);
  endtask

  task automatic push_frame();
    int unsigned kind;
    int unsigned k;
    int unsigned n;
    logic [7:0]  letter;
    frames++;
    burst_q.push_back(CH_PLUS);
    if ($urandom_range(3) == 0) push_noise($urandom_range(2, 1), CH_COLON, CH_COLON);
    burst_q.push_back(CH_COLON);
    kind = $urandom_range(99);
    if (kind < 30) begin
      burst_q.push_back(CH_S);
      n = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 2;
      for (k = 0; k < n; k++) begin
        push_number();
        burst_q.push_back(CH_STAR);
        if ($urandom_range(7) == 0) burst_q.push_back(CH_COLON);
      end
      push_text("OK");
    end else if (kind < 70) begin
      case ($urandom_range(3))
        0:       letter = CH_P;
        1:       letter = CH_I;
        2:       letter = CH_D;
        default: letter = CH_T;
      endcase
      burst_q.push_back(letter);
      if (letter == CH_T && $urandom_range(2) == 0) begin
        push_text("100*");
      end else begin
        n = ($urandom_range(2) == 0) ? $urandom_range(3, 2) : 1;
        for (k = 0; k < n; k++) begin
          push_number();
          burst_q.push_back(CH_STAR);
        end
      end
      push_text("OK");
    end else if (kind < 82) begin
      do letter = byte_except(CH_COLON, CH_COLON);
      while (letter == CH_S || letter == CH_P || letter == CH_I || letter == CH_D ||
             letter == CH_T);
      burst_q.push_back(letter);
      push_number();
      burst_q.push_back(CH_STAR);
      push_text("OK");
    end else if (kind < 96) begin
      // the shortest payloads: OK alone, or a single byte ahead of it
      if ($urandom_range(1) == 0) push_text("KOK");
      else push_text("OK");
    end else begin
      overruns++;
      push_noise(LINE_DEPTH, CH_COLON, CH_K);
      burst_q.push_back(byte_except(CH_COLON, CH_COLON));
    end
  endtask

  task automatic run_session();
    int unsigned n;
    int unsigned k;
    sessions++;
    push_noise($urandom_range(3), CH_C, CH_C);
    push_keyword("CONNECT");
    n = $urandom_range(6, 1);
    for (k = 0; k < n; k++) begin
      push_noise($urandom_range(2), CH_PLUS, CH_ZERO);
      push_frame();
    end
    burst_q.push_back(CH_ZERO);
    push_noise($urandom_range(1), CH_C, CH_C);
    push_keyword("CLOSED");
    flush_burst();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte extremes while waiting, then one full session with a throttle exit frame
    burst_q.push_back(8'h00);
    burst_q.push_back(8'hFF);
    push_text("CONNECT");
    push_text("+:T100*OK");
    push_text("0CLOSED");
    flush_burst();

    while (sent_bytes < 410) run_session();
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("sent %0d bytes over %0d link sessions", sent_bytes, sessions);
    $display("%0d frames, %0d of them overrunning the line buffer", frames, overruns);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule
